### sv/vsr_pkg.sv
// shared types and constants for the voxel solid rasterizer
package vsr_pkg;

  localparam int MAX_X_DEF = 32;
  localparam int MAX_Y_DEF = 32;
  localparam int MAX_Z_DEF = 32;

  localparam logic [3:0] ACT_SET_VOX   = 4'd0;
  localparam logic [3:0] ACT_CLR_VOX   = 4'd1;
  localparam logic [3:0] ACT_SET_BOX   = 4'd2;
  localparam logic [3:0] ACT_CLR_BOX   = 4'd3;
  localparam logic [3:0] ACT_SET_SPH   = 4'd4;
  localparam logic [3:0] ACT_CLR_SPH   = 4'd5;
  localparam logic [3:0] ACT_SET_ELL   = 4'd6;
  localparam logic [3:0] ACT_CLR_ELL   = 4'd7;
  localparam logic [3:0] ACT_READ      = 4'd8;

  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_RED    = 3'd3;
  localparam logic [2:0] REG_GREEN  = 3'd4;
  localparam logic [2:0] REG_BLUE   = 3'd5;
  localparam logic [2:0] REG_ALPHA  = 3'd6;

  // store word: on flag in bit 32, rgba below
  localparam int WORD_W = 33;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_TEST  = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // per-voxel test request handed to the shape tester
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] dz;
  } test_req_t;

endpackage

### sv/voxel_solid_rasterizer_unit.sv
// top level: command decode, grid scan sequencer and voxel store
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+-----------------------
//  command  | start, busy, action, x_a..rad_z          | start && !busy
//  result   | done, voxel_on, colours, bad_argument    | done, one cycle
//  config   | cfg_we, cfg_index, cfg_data              | cfg_we
//
// after reset the whole store is cleared to zero, with busy high.
// single-voxel commands step through ACC then DONE, reads through READ then DONE.
// rejected or empty commands go straight from the accept to DONE.
// boxes scan only the clipped box, spheres and ellipsoids the whole used grid: a TEST
// setup state, then SCAN (test) and ACC (read-modify-write) per voxel, then DONE.
// the store's single port sets the per-voxel rate. results cannot be stalled.
module voxel_solid_rasterizer_unit #(
  parameter int MAX_X = vsr_pkg::MAX_X_DEF,
  parameter int MAX_Y = vsr_pkg::MAX_Y_DEF,
  parameter int MAX_Z = vsr_pkg::MAX_Z_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] action,
  input  logic [7:0] x_a,
  input  logic [8:0] x_b,
  input  logic [7:0] y_a,
  input  logic [8:0] y_b,
  input  logic [7:0] z_a,
  input  logic [8:0] z_b,
  input  logic [7:0] rad_x,
  input  logic [7:0] rad_y,
  input  logic [7:0] rad_z,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic       voxel_on,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  output logic       bad_argument
);

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  // configuration registers
  logic [5:0] size_x, size_y, size_z;
  logic [7:0] paint_r, paint_g, paint_b, paint_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 6'd32; size_y <= 6'd32; size_z <= 6'd32;
      paint_r <= '0; paint_g <= '0; paint_b <= '0; paint_a <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsr_pkg::REG_SIZE_X: size_x <= cfg_data[5:0];
        vsr_pkg::REG_SIZE_Y: size_y <= cfg_data[5:0];
        vsr_pkg::REG_SIZE_Z: size_z <= cfg_data[5:0];
        vsr_pkg::REG_RED:    paint_r <= cfg_data;
        vsr_pkg::REG_GREEN:  paint_g <= cfg_data;
        vsr_pkg::REG_BLUE:   paint_b <= cfg_data;
        vsr_pkg::REG_ALPHA:  paint_a <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective extents
  logic [8:0] ex, ey, ez;
  always_comb begin
    ex = (9'(size_x) > 9'(MAX_X)) ? 9'(MAX_X) : 9'(size_x);
    ey = (9'(size_y) > 9'(MAX_Y)) ? 9'(MAX_Y) : 9'(size_y);
    ez = (9'(size_z) > 9'(MAX_Z)) ? 9'(MAX_Z) : 9'(size_z);
  end

  // latched command
  logic [3:0] act;
  logic [7:0] xa, ya, za;
  logic [8:0] hx, hy, hz;
  logic [7:0] ci, cj, ck;
  logic       is_set, is_box;
  vsr_pkg::state_t state;
  logic [AW:0] clr_cnt;

  // clipped box bounds from the port values
  logic [8:0] bx, by, bz;
  always_comb begin
    bx = (x_b > ex) ? ex : x_b;
    by = (y_b > ey) ? ey : y_b;
    bz = (z_b > ez) ? ez : z_b;
  end

  logic in_grid;
  assign in_grid = 9'(x_a) < ex && 9'(y_a) < ey && 9'(z_a) < ez;

  // scan bounds: lower is ci/cj/ck start value
  logic [7:0] lo_x, lo_y, lo_z;

  // distances for the shape tester
  vsr_pkg::test_req_t req;
  always_comb begin
    req.action = act;
    req.dx = (ci > xa) ? ci - xa : xa - ci;
    req.dy = (cj > ya) ? cj - ya : ya - cj;
    req.dz = (ck > za) ? ck - za : za - ck;
  end

  logic hit;
  vsr_shape u_shape (
    .clk  (clk),
    .load (start && !busy),
    .rad_x(rad_x), .rad_y(rad_y), .rad_z(rad_z),
    .step (state == vsr_pkg::ST_SCAN),
    .req  (req),
    .hit  (hit)
  );

  // store port
  logic                       we;
  logic [AW-1:0]              addr;
  logic [vsr_pkg::WORD_W-1:0] wdata, rdata;
  logic [31:0]                lin;
  logic [7:0]                 ai, aj, ak;

  // in idle the store is addressed from the command ports, so the
  // addressed voxel is read at the accepting edge
  always_comb begin
    if (state == vsr_pkg::ST_IDLE) begin
      ai = x_a; aj = y_a; ak = z_a;
    end else begin
      ai = ci; aj = cj; ak = ck;
    end
  end

  assign lin = (32'(ai) * 32'(MAX_Y) + 32'(aj)) * 32'(MAX_Z) + 32'(ak);

  always_comb begin
    we    = 1'b0;
    addr  = AW'(lin);
    wdata = {is_set, paint_r, paint_g, paint_b, paint_a};
    if (state == vsr_pkg::ST_CLEAR) begin
      we    = 1'b1;
      addr  = clr_cnt[AW-1:0];
      wdata = '0;
    end else if (state == vsr_pkg::ST_ACC) begin
      we = is_box || hit;
      if (!is_set) wdata = {1'b0, rdata[31:0]};
    end
  end

  vsr_ram #(.WIDTH(vsr_pkg::WORD_W), .DEPTH(CELLS)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // scan position advance
  logic last_k, last_j, last_i;
  assign last_k = 9'(ck) + 9'd1 >= hz;
  assign last_j = 9'(cj) + 9'd1 >= hy;
  assign last_i = 9'(ci) + 9'd1 >= hx;

  assign busy = state != vsr_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= vsr_pkg::ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        vsr_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + (AW+1)'(1);
          if (clr_cnt == (AW+1)'(CELLS - 1)) state <= vsr_pkg::ST_IDLE;
        end
        vsr_pkg::ST_IDLE: begin
          if (start) begin
            act <= action; xa <= x_a; ya <= y_a; za <= z_a;
            is_set <= !action[0];
            voxel_on <= 1'b0; red_out <= '0; green_out <= '0;
            blue_out <= '0; alpha_out <= '0; bad_argument <= 1'b0;
            ci <= x_a; cj <= y_a; ck <= z_a;
            case (action)
              vsr_pkg::ACT_SET_VOX, vsr_pkg::ACT_CLR_VOX: begin
                is_box <= 1'b1;
                lo_x <= x_a; lo_y <= y_a; lo_z <= z_a;
                hx <= 9'(x_a) + 9'd1; hy <= 9'(y_a) + 9'd1; hz <= 9'(z_a) + 9'd1;
                if (in_grid) state <= vsr_pkg::ST_ACC;
                else begin bad_argument <= 1'b1; state <= vsr_pkg::ST_DONE; end
              end
              vsr_pkg::ACT_SET_BOX, vsr_pkg::ACT_CLR_BOX: begin
                is_box <= 1'b1;
                lo_x <= x_a; lo_y <= y_a; lo_z <= z_a;
                hx <= bx; hy <= by; hz <= bz;
                if (9'(x_a) < bx && 9'(y_a) < by && 9'(z_a) < bz)
                  state <= vsr_pkg::ST_TEST;
                else state <= vsr_pkg::ST_DONE;
              end
              vsr_pkg::ACT_SET_SPH, vsr_pkg::ACT_CLR_SPH,
              vsr_pkg::ACT_SET_ELL, vsr_pkg::ACT_CLR_ELL: begin
                is_box <= 1'b0;
                lo_x <= '0; lo_y <= '0; lo_z <= '0;
                ci <= '0; cj <= '0; ck <= '0;
                hx <= ex; hy <= ey; hz <= ez;
                if (action[1] && (rad_x == '0 || rad_y == '0 || rad_z == '0)) begin
                  bad_argument <= 1'b1; state <= vsr_pkg::ST_DONE;
                end else if (ex == '0 || ey == '0 || ez == '0)
                  state <= vsr_pkg::ST_DONE;
                else state <= vsr_pkg::ST_TEST;
              end
              vsr_pkg::ACT_READ: begin
                if (in_grid) state <= vsr_pkg::ST_READ;
                else begin bad_argument <= 1'b1; state <= vsr_pkg::ST_DONE; end
              end
              default: begin
                bad_argument <= 1'b1; state <= vsr_pkg::ST_DONE;
              end
            endcase
          end
        end
        // radius products are finished in the TEST and first SCAN states, before the first test
        vsr_pkg::ST_TEST: state <= vsr_pkg::ST_SCAN;
        vsr_pkg::ST_SCAN: state <= vsr_pkg::ST_ACC;
        vsr_pkg::ST_ACC: begin
          if (last_k) begin
            ck <= lo_z;
            if (last_j) begin
              cj <= lo_y;
              if (last_i) state <= vsr_pkg::ST_DONE;
              else ci <= ci + 8'd1;
            end else cj <= cj + 8'd1;
          end else ck <= ck + 8'd1;
          if (!(last_k && last_j && last_i)) state <= vsr_pkg::ST_SCAN;
        end
        vsr_pkg::ST_READ: begin
          state <= vsr_pkg::ST_DONE;
          voxel_on  <= rdata[32];
          red_out   <= rdata[31:24];
          green_out <= rdata[23:16];
          blue_out  <= rdata[15:8];
          alpha_out <= rdata[7:0];
        end
        vsr_pkg::ST_DONE: begin
          done  <= 1'b1;
          state <= vsr_pkg::ST_IDLE;
        end
        default: state <= vsr_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

### sv/vsr_ram.sv
// generic single-port ram with registered read
module vsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/vsr_shape.sv
// sphere and ellipsoid membership test, multi-cycle
module vsr_shape (
  input  logic              clk,
  input  logic              load,
  input  logic [7:0]        rad_x,
  input  logic [7:0]        rad_y,
  input  logic [7:0]        rad_z,
  input  logic              step,
  input  vsr_pkg::test_req_t req,
  output logic              hit
);

  // per command: squared radii and products
  logic [15:0] ax, ay, az;
  logic [31:0] ayz, axz, axy;
  logic [47:0] lim;
  logic [1:0]  setup_cnt;

  always_ff @(posedge clk) begin
    if (load) begin
      ax <= 16'(rad_x) * 16'(rad_x);
      ay <= 16'(rad_y) * 16'(rad_y);
      az <= 16'(rad_z) * 16'(rad_z);
      setup_cnt <= 2'd0;
    end else if (setup_cnt != 2'd3) begin
      setup_cnt <= setup_cnt + 2'd1;
      if (setup_cnt == 2'd0) begin
        ayz <= 32'(ay) * 32'(az);
        axz <= 32'(ax) * 32'(az);
        axy <= 32'(ax) * 32'(ay);
      end else if (setup_cnt == 2'd1) begin
        lim <= 48'(ax) * 48'(ayz);
      end
    end
  end

  // per voxel: squares, then weighted sum and compare
  logic [15:0] sx, sy, sz;
  logic [49:0] wsum;

  always_ff @(posedge clk) begin
    if (step) begin
      sx <= 16'(req.dx) * 16'(req.dx);
      sy <= 16'(req.dy) * 16'(req.dy);
      sz <= 16'(req.dz) * 16'(req.dz);
    end
  end

  always_comb begin
    if (req.action == vsr_pkg::ACT_SET_SPH || req.action == vsr_pkg::ACT_CLR_SPH) begin
      wsum = 50'(sx) + 50'(sy) + 50'(sz);
      hit  = wsum <= 50'(ax);
    end else begin
      wsum = 50'(48'(sx) * 48'(ayz)) + 50'(48'(sy) * 48'(axz)) + 50'(48'(sz) * 48'(axy));
      hit  = wsum <= 50'(lim);
    end
  end

endmodule

### sim/tb_voxel_solid_rasterizer_unit.sv
// testbench for voxel_solid_rasterizer_unit with a self-checking voxel store predictor
`timescale 1ns / 1ps

module tb_voxel_solid_rasterizer_unit;

  localparam int GRID = vsr_pkg::MAX_X_DEF;
  localparam int CELL_COUNT = vsr_pkg::MAX_X_DEF * vsr_pkg::MAX_Y_DEF * vsr_pkg::MAX_Z_DEF;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  typedef struct {
    logic [3:0] action;
    logic [7:0] x_a;
    logic [8:0] x_b;
    logic [7:0] y_a;
    logic [8:0] y_b;
    logic [7:0] z_a;
    logic [8:0] z_b;
    logic [7:0] rad_x;
    logic [7:0] rad_y;
    logic [7:0] rad_z;
  } voxel_cmd_t;

  typedef struct {
    logic       on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad;
  } voxel_res_t;

  // voxel store model and queue of expected answers
  class voxel_scoreboard;
    bit [32:0]  cells [CELL_COUNT];
    int         ext_reg [3];
    bit [7:0]   paint [4];
    voxel_res_t answer_q [$];
    int         errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (ext_reg[i]) ext_reg[i] = GRID;
      foreach (paint[i]) paint[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        vsr_pkg::REG_SIZE_X: ext_reg[0] = data[5:0];
        vsr_pkg::REG_SIZE_Y: ext_reg[1] = data[5:0];
        vsr_pkg::REG_SIZE_Z: ext_reg[2] = data[5:0];
        vsr_pkg::REG_RED:    paint[0] = data;
        vsr_pkg::REG_GREEN:  paint[1] = data;
        vsr_pkg::REG_BLUE:   paint[2] = data;
        vsr_pkg::REG_ALPHA:  paint[3] = data;
        default: ;
      endcase
    endfunction

    function longint sqd(int a, int b);
      longint d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function void paint_cell(int i, int j, int k, bit set_it);
      int n;
      n = (i * vsr_pkg::MAX_Y_DEF + j) * vsr_pkg::MAX_Z_DEF + k;
      if (set_it) cells[n] = {1'b1, paint[0], paint[1], paint[2], paint[3]};
      else cells[n][32] = 1'b0;
    endfunction

    // predict the answer of one accepted command and update the store
    function void note_cmd(voxel_cmd_t c);
      voxel_res_t r;
      int ex, ey, ez, hx, hy, hz, n;
      bit set_it, in_grid;
      longint ax, ay, az, lim, s;
      ex = (ext_reg[0] > vsr_pkg::MAX_X_DEF) ? vsr_pkg::MAX_X_DEF : ext_reg[0];
      ey = (ext_reg[1] > vsr_pkg::MAX_Y_DEF) ? vsr_pkg::MAX_Y_DEF : ext_reg[1];
      ez = (ext_reg[2] > vsr_pkg::MAX_Z_DEF) ? vsr_pkg::MAX_Z_DEF : ext_reg[2];
      r = '{default: '0};
      set_it = !c.action[0];
      in_grid = c.x_a < ex && c.y_a < ey && c.z_a < ez;
      ax = longint'(c.rad_x) * c.rad_x;
      ay = longint'(c.rad_y) * c.rad_y;
      az = longint'(c.rad_z) * c.rad_z;
      case (c.action)
        vsr_pkg::ACT_SET_VOX, vsr_pkg::ACT_CLR_VOX: begin
          if (in_grid) paint_cell(c.x_a, c.y_a, c.z_a, set_it);
          else r.bad = 1'b1;
        end
        vsr_pkg::ACT_SET_BOX, vsr_pkg::ACT_CLR_BOX: begin
          hx = (c.x_b > ex) ? ex : c.x_b;
          hy = (c.y_b > ey) ? ey : c.y_b;
          hz = (c.z_b > ez) ? ez : c.z_b;
          for (int i = c.x_a; i < hx; i++)
            for (int j = c.y_a; j < hy; j++)
              for (int k = c.z_a; k < hz; k++) paint_cell(i, j, k, set_it);
        end
        vsr_pkg::ACT_SET_SPH, vsr_pkg::ACT_CLR_SPH: begin
          for (int i = 0; i < ex; i++)
            for (int j = 0; j < ey; j++)
              for (int k = 0; k < ez; k++)
                if (sqd(i, c.x_a) + sqd(j, c.y_a) + sqd(k, c.z_a) <= ax)
                  paint_cell(i, j, k, set_it);
        end
        vsr_pkg::ACT_SET_ELL, vsr_pkg::ACT_CLR_ELL: begin
          if (c.rad_x == 0 || c.rad_y == 0 || c.rad_z == 0) begin
            r.bad = 1'b1;
          end else begin
            lim = ax * ay * az;
            for (int i = 0; i < ex; i++)
              for (int j = 0; j < ey; j++)
                for (int k = 0; k < ez; k++) begin
                  s = sqd(i, c.x_a) * ay * az + sqd(j, c.y_a) * ax * az
                    + sqd(k, c.z_a) * ax * ay;
                  if (s <= lim) paint_cell(i, j, k, set_it);
                end
          end
        end
        vsr_pkg::ACT_READ: begin
          if (in_grid) begin
            n = (int'(c.x_a) * vsr_pkg::MAX_Y_DEF + c.y_a) * vsr_pkg::MAX_Z_DEF + c.z_a;
            {r.on, r.red, r.green, r.blue, r.alpha} = cells[n];
          end else begin
            r.bad = 1'b1;
          end
        end
        default: r.bad = 1'b1;
      endcase
      answer_q.push_back(r);
    endfunction

    // compare one result transaction with the oldest expected answer
    function void check_res(voxel_res_t got);
      voxel_res_t want;
      logic [7:0] w [6];
      logic [7:0] g [6];
      string names [6];
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      want = answer_q.pop_front();
      names = '{"voxel_on", "red_out", "green_out", "blue_out", "alpha_out",
                "bad_argument"};
      w = '{want.on, want.red, want.green, want.blue, want.alpha, want.bad};
      g = '{got.on, got.red, got.green, got.blue, got.alpha, got.bad};
      for (int f = 0; f < 6; f++)
        if (w[f] !== g[f]) begin
          $display("%0t: %s expected %0h actual %0h", $time, names[f], w[f], g[f]);
          errors++;
        end
    endfunction
  endclass

  logic       clk, rst, start, busy, cfg_we, done;
  logic [3:0] action;
  logic [7:0] x_a, y_a, z_a, rad_x, rad_y, rad_z, cfg_data;
  logic [8:0] x_b, y_b, z_b;
  logic [2:0] cfg_index;
  logic       voxel_on, bad_argument;
  logic [7:0] red_out, green_out, blue_out, alpha_out;

  voxel_scoreboard sb;
  bit              no_idle;
  int              cur_ext;

  voxel_solid_rasterizer_unit u_top (
    .clk, .rst, .start, .busy, .action, .x_a, .x_b, .y_a, .y_b, .z_a, .z_b,
    .rad_x, .rad_y, .rad_z, .cfg_we, .cfg_index, .cfg_data, .done, .voxel_on,
    .red_out, .green_out, .blue_out, .alpha_out, .bad_argument
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_voxel_solid_rasterizer_unit: done, errors");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_res('{voxel_on, red_out, green_out, blue_out, alpha_out, bad_argument});
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one command and wait for its transaction
  task automatic send_cmd(voxel_cmd_t c);
    int gap;
    bit taken;
    gap = gap_len();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {action, x_a, x_b, y_a, y_b, z_a, z_b} =
      {c.action, c.x_a, c.x_b, c.y_a, c.y_b, c.z_a, c.z_b};
    {rad_x, rad_y, rad_z} = {c.rad_x, c.rad_y, c.rad_z};
    start = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(posedge clk);
      if (taken) sb.note_cmd(c);
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.answer_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_grid(logic [7:0] sx, logic [7:0] sy, logic [7:0] sz);
    wait_idle();
    write_reg(vsr_pkg::REG_SIZE_X, sx);
    write_reg(vsr_pkg::REG_SIZE_Y, sy);
    write_reg(vsr_pkg::REG_SIZE_Z, sz);
    cur_ext = (sx > sy) ? sx : sy;
    if (sz > cur_ext) cur_ext = sz;
  endtask

  task automatic set_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    write_reg(vsr_pkg::REG_RED, r);
    write_reg(vsr_pkg::REG_GREEN, g);
    write_reg(vsr_pkg::REG_BLUE, b);
    write_reg(vsr_pkg::REG_ALPHA, a);
  endtask

  function automatic voxel_cmd_t mk(logic [3:0] act, logic [7:0] xa, logic [8:0] xb,
                                    logic [7:0] ya, logic [8:0] yb, logic [7:0] za,
                                    logic [8:0] zb, logic [7:0] rx, logic [7:0] ry,
                                    logic [7:0] rz);
    return '{act, xa, xb, ya, yb, za, zb, rx, ry, rz};
  endfunction

  // coordinate mostly near the used grid, sometimes anywhere
  function automatic logic [7:0] rnd_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, cur_ext + 1);
  endfunction

  function automatic logic [8:0] rnd_bound();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 511);
    return $urandom_range(0, cur_ext + 2);
  endfunction

  function automatic voxel_cmd_t rnd_cmd();
    voxel_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) c.action = vsr_pkg::ACT_READ;
    else if (r < 55)
      c.action = $urandom_range(vsr_pkg::ACT_SET_VOX, vsr_pkg::ACT_CLR_VOX);
    else if (r < 95)
      c.action = $urandom_range(vsr_pkg::ACT_SET_BOX, vsr_pkg::ACT_CLR_ELL);
    else c.action = $urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI);
    c.x_a = rnd_coord();
    c.y_a = rnd_coord();
    c.z_a = rnd_coord();
    c.x_b = rnd_bound();
    c.y_b = rnd_bound();
    c.z_b = rnd_bound();
    c.rad_x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
    c.rad_y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
    c.rad_z = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
    return c;
  endfunction

  initial begin
    sb = new();
    {rst, start, cfg_we, cfg_index, cfg_data} = '0;
    rst = 1'b1;
    {action, x_a, x_b, y_a, y_b, z_a, z_b, rad_x, rad_y, rad_z} = '0;
    no_idle = 1'b0;
    cur_ext = GRID;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: full grid, point edges, clipping, full box and a small sphere
    send_cmd(mk(vsr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();
    set_paint(8'hff, 8'h00, 8'ha5, 8'h5a);
    send_cmd(mk(vsr_pkg::ACT_SET_VOX, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 32, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_SET_VOX, 0, 0, 32, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_CLR_VOX, 0, 0, 0, 0, 255, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_CLR_VOX, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_SET_BOX, 0, 256, 0, 511, 0, 256, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_CLR_BOX, 5, 5, 5, 9, 5, 9, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_CLR_SPH, 16, 0, 16, 0, 16, 0, 3, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 16, 0, 16, 0, 19, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 16, 0, 16, 0, 20, 0, 0, 0, 0));

    // directed: small grid, degenerate shapes and unused codes
    set_grid(8, 8, 8);
    set_paint(8'h00, 8'hff, 8'h3c, 8'hff);
    send_cmd(mk(vsr_pkg::ACT_SET_SPH, 3, 0, 4, 0, 5, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_SET_SPH, 255, 0, 255, 0, 255, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_SET_ELL, 2, 0, 2, 0, 2, 0, 3, 0, 2));
    send_cmd(mk(vsr_pkg::ACT_SET_ELL, 255, 0, 0, 0, 255, 0, 255, 255, 255));
    send_cmd(mk(vsr_pkg::ACT_CLR_ELL, 4, 0, 4, 0, 4, 0, 1, 2, 3));
    send_cmd(mk(ACT_UNUSED_LO, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_cmd(mk(ACT_UNUSED_HI, 255, 511, 255, 511, 255, 511, 255, 255, 255));
    send_cmd(mk(vsr_pkg::ACT_READ, 4, 0, 4, 0, 4, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_READ, 3, 0, 4, 0, 5, 0, 0, 0, 0));

    // empty grid, then an extent above the maximum
    set_grid(0, 8, 8);
    send_cmd(mk(vsr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(vsr_pkg::ACT_SET_SPH, 0, 0, 0, 0, 0, 0, 9, 0, 0));
    set_grid(63, 1, 1);
    send_cmd(mk(vsr_pkg::ACT_READ, 31, 0, 0, 0, 0, 0, 0, 0, 0));

    // random phases over several grid sizes and paints
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) set_grid(40, $urandom_range(1, 4), $urandom_range(1, 4));
      else set_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
      set_paint($urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
      no_idle = (ph == 1);
      repeat (19) send_cmd(rnd_cmd());
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.answer_q.size() == 0)
      $display("tb_voxel_solid_rasterizer_unit: done, clean");
    else
      $display("tb_voxel_solid_rasterizer_unit: done, errors");
    $finish;
  end

endmodule

### voxel_solid_rasterizer_unit.f
sv/vsr_pkg.sv
sv/vsr_ram.sv
sv/vsr_shape.sv
sv/voxel_solid_rasterizer_unit.sv
sim/tb_voxel_solid_rasterizer_unit.sv
